### rtl/clfp_pkg.sv
// Package for the command/length frame parser: types, codes and constants.
package clfp_pkg;

  localparam int unsigned LEN_FIELD_BYTES = 4;
  localparam int unsigned SEEN_W = 3;
  localparam int unsigned REM_W = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_IMAGE = 3'd1,
    ST_POSE  = 3'd2,
    ST_RGB   = 3'd3,
    ST_DEPTH = 3'd4,
    ST_EDGE  = 3'd5,
    ST_NODE  = 3'd6
  } state_t;

  typedef enum logic [1:0] {
    FT_RGB   = 2'd0,
    FT_DEPTH = 2'd1,
    FT_EDGE  = 2'd2,
    FT_NODE  = 2'd3
  } frame_type_t;

  localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_GROUP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_GROUP  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RGB         = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE        = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NODE        = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEN    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_LEN    = 8'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic        last;
    frame_type_t ftype;
    logic [7:0]  data;
  } result_t;

endpackage

### rtl/command_length_frame_parser_top.sv
// Top level of the command/length frame parser.
//
// Input stream (s_*): one byte per transaction in s_tdata[7:0]. A group byte
// opens an image or pose-graph header, a subtype byte follows. Image frames
// then carry a 4-byte little-endian length; pose-graph frames use the
// configured fixed length. Each payload byte comes out on m_* tagged with its
// frame type and tlast on the final byte. An unknown group byte gives an
// error result; a zero-length image gives an empty-frame result.
// Config channel (cfg_*): register index and data, always ready; write only
// while the block is idle.
// Throughput: one byte per cycle while s_tready is high. Results pass
// through an output register backed by a one-entry skid register, so the
// parser keeps accepting while one result waits; s_tready drops only when
// both are full.
// Reset (rst, synchronous): parser idle, registers to their defaults, no
// result pending.
module command_length_frame_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // last_of_frame
  output logic [3:0]  m_tuser,   // [1:0] frame_type, [3:2] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [clfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clfp_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]  image_group_code;
  logic [7:0]  pose_group_code;
  logic [7:0]  rgb_code;
  logic [7:0]  depth_code;
  logic [7:0]  edge_code;
  logic [7:0]  node_code;
  logic [15:0] edge_payload_length;
  logic [15:0] node_payload_length;

  clfp_pkg::state_t state, state_next;
  logic [clfp_pkg::SEEN_W-1:0] seen, seen_next;
  logic [clfp_pkg::REM_W-1:0]  remaining, remaining_next, len_acc;

  clfp_pkg::result_t res, out_reg, skid;
  logic res_valid, out_valid, skid_valid;
  logic in_fire;
  clfp_pkg::frame_type_t cur_type;
  logic [7:0] b;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign b         = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_group_code    <= 8'd0;
      pose_group_code     <= 8'd1;
      rgb_code            <= 8'd0;
      depth_code          <= 8'd1;
      edge_code           <= 8'd2;
      node_code           <= 8'd3;
      edge_payload_length <= 16'd64;
      node_payload_length <= 16'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        clfp_pkg::REG_IMAGE_GROUP: image_group_code    <= cfg_data[7:0];
        clfp_pkg::REG_POSE_GROUP:  pose_group_code     <= cfg_data[7:0];
        clfp_pkg::REG_RGB:         rgb_code            <= cfg_data[7:0];
        clfp_pkg::REG_DEPTH:       depth_code          <= cfg_data[7:0];
        clfp_pkg::REG_EDGE:        edge_code           <= cfg_data[7:0];
        clfp_pkg::REG_NODE:        node_code           <= cfg_data[7:0];
        clfp_pkg::REG_EDGE_LEN:    edge_payload_length <= cfg_data;
        clfp_pkg::REG_NODE_LEN:    node_payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= clfp_pkg::ST_IDLE;
      seen      <= '0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      seen      <= seen_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    case (state)
      clfp_pkg::ST_DEPTH: cur_type = clfp_pkg::FT_DEPTH;
      clfp_pkg::ST_EDGE:  cur_type = clfp_pkg::FT_EDGE;
      clfp_pkg::ST_NODE:  cur_type = clfp_pkg::FT_NODE;
      default:            cur_type = clfp_pkg::FT_RGB;
    endcase
  end

  // little-endian length: byte lane selected by bytes seen so far
  assign len_acc = remaining | (clfp_pkg::REM_W'(b) << {seen[1:0], 3'b000});

  always_comb begin
    state_next     = state;
    seen_next      = seen;
    remaining_next = remaining;
    res_valid      = 1'b0;
    res            = '0;
    if (in_fire) begin
      case (state)
        clfp_pkg::ST_IMAGE: begin
          seen_next      = '0;
          remaining_next = '0;
          if (b == rgb_code) state_next = clfp_pkg::ST_RGB;
          else if (b == depth_code) state_next = clfp_pkg::ST_DEPTH;
          else state_next = clfp_pkg::ST_IDLE;
        end
        clfp_pkg::ST_POSE: begin
          seen_next = '0;
          if (b == edge_code && edge_payload_length != 16'd0) begin
            remaining_next = clfp_pkg::REM_W'(edge_payload_length);
            state_next     = clfp_pkg::ST_EDGE;
          end else if (b != edge_code && b == node_code && node_payload_length != 16'd0) begin
            remaining_next = clfp_pkg::REM_W'(node_payload_length);
            state_next     = clfp_pkg::ST_NODE;
          end else begin
            remaining_next = '0;
            state_next     = clfp_pkg::ST_IDLE;
          end
        end
        clfp_pkg::ST_RGB, clfp_pkg::ST_DEPTH, clfp_pkg::ST_EDGE, clfp_pkg::ST_NODE: begin
          res.ftype = cur_type;
          if ((state == clfp_pkg::ST_RGB || state == clfp_pkg::ST_DEPTH) &&
              seen < clfp_pkg::SEEN_W'(clfp_pkg::LEN_FIELD_BYTES)) begin
            seen_next      = seen + 1'b1;
            remaining_next = len_acc;
            if (seen_next == clfp_pkg::SEEN_W'(clfp_pkg::LEN_FIELD_BYTES) &&
                len_acc == '0) begin
              state_next = clfp_pkg::ST_IDLE;
              seen_next  = '0;
              res_valid  = 1'b1;
              res.last   = 1'b1;
              res.status = clfp_pkg::STATUS_EMPTY;
            end
          end else begin
            res_valid  = 1'b1;
            res.data   = b;
            res.status = clfp_pkg::STATUS_PAYLOAD;
            if (remaining <= clfp_pkg::REM_W'(1)) begin
              state_next     = clfp_pkg::ST_IDLE;
              seen_next      = '0;
              remaining_next = '0;
              res.last       = 1'b1;
            end else begin
              remaining_next = remaining - 1'b1;
            end
          end
        end
        default: begin
          seen_next      = '0;
          remaining_next = '0;
          if (b == image_group_code) state_next = clfp_pkg::ST_IMAGE;
          else if (b == pose_group_code) state_next = clfp_pkg::ST_POSE;
          else begin
            state_next = clfp_pkg::ST_IDLE;
            res_valid  = 1'b1;
            res.status = clfp_pkg::STATUS_UNKNOWN;
          end
        end
      endcase
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_reg <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg.data;
  assign m_tlast  = out_reg.last;
  assign m_tuser  = {out_reg.status, out_reg.ftype};

endmodule

### rtl/command_length_frame_parser_checker.sv
// Port-level assertions for the frame parser top level, with its bind.
module command_length_frame_parser_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [3:0] m_tuser
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[3:2] != 2'd3)
    else $error("undefined status code");

  a_unknown_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3:2] == clfp_pkg::STATUS_UNKNOWN) |->
      (m_tdata == 8'd0 && !m_tlast && m_tuser[1:0] == 2'd0))
    else $error("unknown-command result carries data");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3:2] == clfp_pkg::STATUS_EMPTY) |->
      (m_tlast && m_tdata == 8'd0 && !m_tuser[1]))
    else $error("empty-frame result malformed");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind command_length_frame_parser_top command_length_frame_parser_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
